FILE: src/gal_pkg.sv
`default_nettype none

package gal_pkg;

   // Operation codes of an input word
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEXT = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPACE_CHAR    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPACE_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GLYPH_SPACING = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MONO_ADVANCE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_WIDTH     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GLYPH_COUNT   = 3'd5;
   localparam int unsigned CSR_DATA_BITS = 16;

   // Break causes
   localparam logic [1:0] CAUSE_END     = 2'd0;
   localparam logic [1:0] CAUSE_NEWLINE = 2'd1;
   localparam logic [1:0] CAUSE_SPACE   = 2'd2;
   localparam logic [1:0] CAUSE_MID     = 2'd3;

   // Character codes
   localparam logic [15:0] CHAR_NUL     = 16'd0;
   localparam logic [15:0] CHAR_NEWLINE = 16'd10;
   localparam logic [15:0] CHAR_UPPER_A = 16'd65;
   localparam logic [15:0] CHAR_LOWER_A = 16'd97;
   localparam logic [15:0] CHAR_LOWER_Z = 16'd122;

   // Saturation limit of the position
   localparam logic [15:0] POS_MAX = 16'hFFFF;

   typedef struct packed {
      logic        operation;
      logic [11:0] entry_index;
      logic [31:0] entry_code;
      logic [7:0]  entry_width;
      logic [15:0] text_char;
      logic        text_last;
   } req_word_type;

   typedef struct packed {
      logic [15:0] break_count;
      logic [1:0]  break_cause;
   } rsp_word_type;

   // One glyph table entry
   typedef struct packed {
      logic [31:0] code;
      logic [7:0]  width;
   } entry_type;

   // Search request from the line control
   typedef struct packed {
      logic        start;
      logic [31:0] code;
      logic [12:0] count;
   } search_cmd_type;

   // Search outcome, valid for one cycle with done
   typedef struct packed {
      logic       done;
      logic       found;
      logic [7:0] width;
   } search_res_type;

endpackage

`default_nettype wire

FILE: src/gal_table_ram.sv
`default_nettype none

module gal_table_ram #(
   parameter int unsigned TABLE_ENTRIES = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0]   addr,
   input  wire gal_pkg::entry_type                 wr_data,
   output gal_pkg::entry_type                      rd_data
);
   import gal_pkg::*;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   // Single port: write on load; registered read of the addressed entry on every edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/gal_search.sv
`default_nettype none

module gal_search #(
   parameter int unsigned TABLE_ENTRIES = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire gal_pkg::search_cmd_type            cmd,
   input  wire gal_pkg::entry_type                 rd_data,
   output logic [$clog2(TABLE_ENTRIES)-1:0]        rd_addr,
   output gal_pkg::search_res_type                 res
);
   import gal_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);
   localparam int unsigned IW = AW + 2;

   typedef enum logic {
      S_IDLE,
      S_CMP
   } state_type;

   state_type           state_ff, state_in;
   logic signed [IW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [IW-1:0] hi_start, mid_start, mid_cmp, lo_nx, hi_nx, mid_nx;
   logic [31:0]         code_ff, code_in;
   search_res_type      res_ff, res_in;
   logic [16:0]         count_wide, n_entries;

   // Clamp the entry count to the table size
   always_comb begin
      count_wide = {4'b0, cmd.count};
      n_entries  = (count_wide > 17'(TABLE_ENTRIES)) ? 17'(TABLE_ENTRIES) : count_wide;
      hi_start   = IW'(n_entries) - IW'(1);
      mid_start  = hi_start >>> 1;
   end

   // Narrow the interval after each probe
   always_comb begin
      mid_cmp = (lo_ff + hi_ff) >>> 1;
      if (rd_data.code < code_ff) begin
         lo_nx = mid_cmp + IW'(1);
         hi_nx = hi_ff;
      end else begin
         lo_nx = lo_ff;
         hi_nx = mid_cmp - IW'(1);
      end
      mid_nx = (lo_nx + hi_nx) >>> 1;
   end

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      code_in  = code_ff;
      res_in   = '0;
      rd_addr  = mid_nx[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            rd_addr = mid_start[AW-1:0];
            if (cmd.start) begin
               code_in = cmd.code;
               lo_in   = '0;
               hi_in   = hi_start;
               if (n_entries == 17'd0) begin
                  res_in.done = 1'b1;
               end else begin
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            if (rd_data.code == code_ff) begin
               res_in.done  = 1'b1;
               res_in.found = 1'b1;
               res_in.width = rd_data.width;
               state_in     = S_IDLE;
            end else if (lo_nx > hi_nx) begin
               res_in.done = 1'b1;
               state_in    = S_IDLE;
            end else begin
               lo_in = lo_nx;
               hi_in = hi_nx;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         res_ff   <= res_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      code_ff <= code_in;
   end

   assign res = res_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == S_IDLE)
      else $error("search started while busy");

   a_interval_open: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> lo_ff <= hi_ff)
      else $error("probe issued on an empty interval");

   a_cmp_after_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_CMP) |-> $past(cmd.start))
      else $error("probing began without a start");

endmodule

`default_nettype wire

FILE: src/glyph_advance_line_breaker_top.sv
// Load word: taken while idle, table written at the accepting edge.
// Text word: CHAR, then SRCH1 (lookup) and SRCH2 (uppercase retry of a lowercase
// miss), then ADD and FINISH; a space or a fixed advance skips the lookups, and an
// end character or a finished line goes from CHAR to FINISH. Result is registered.
// One word at a time; a result held by rsp_stall holds the next result and the input.
// Synchronous reset clears line state and registers; table contents stay undefined.
`default_nettype none

module glyph_advance_line_breaker_top #(
   parameter int unsigned TABLE_ENTRIES = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire gal_pkg::req_word_type                  req_word,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output gal_pkg::rsp_word_type                       rsp_word,
   input  wire logic                                   csr_write,
   input  wire logic [gal_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [gal_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import gal_pkg::*;

   localparam int unsigned AW = $clog2(TABLE_ENTRIES);

   typedef enum logic [2:0] {
      T_IDLE,
      T_CHAR,
      T_SRCH1,
      T_SRCH2,
      T_ADD,
      T_FINISH
   } state_type;

   state_type          state_ff;

   // Configuration registers
   logic [15:0]        space_char_ff;
   logic [9:0]         space_width_ff;
   logic signed [7:0]  glyph_spacing_ff;
   logic [9:0]         mono_advance_ff;
   logic [15:0]        max_width_ff;
   logic [12:0]        glyph_count_ff;

   // Line state
   logic signed [19:0] sum_ff;
   logic [15:0]        pos_ff;
   logic signed [16:0] lsp_ff;
   logic               line_done_ff;

   // Word in flight
   logic [15:0]        char_ff;
   logic               last_ff;
   logic signed [11:0] adv_ff;
   logic               emit_ff;
   rsp_word_type       result_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;

   logic               req_accept, load_write, finish_wait, rsp_load;
   logic [16:0]        idx_wide;
   logic [AW-1:0]      ram_addr, srch_addr;
   entry_type          wr_entry, rd_entry;
   search_cmd_type     srch_cmd;
   search_res_type     srch_res;
   logic               is_space, is_end, is_lower;
   logic [15:0]        upper_char;
   logic signed [11:0] glyph_adv, space_adv;
   logic signed [20:0] sum_wide;
   logic signed [19:0] sum_new;
   logic signed [16:0] lsp_new;
   logic [15:0]        pos_new;
   logic               over_width;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != T_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   // Table write port from load words; drop loads beyond the table
   always_comb begin
      idx_wide       = {5'b0, req_word.entry_index};
      load_write     = req_accept && (req_word.operation == OP_LOAD)
                       && (idx_wide < 17'(TABLE_ENTRIES));
      wr_entry.code  = req_word.entry_code;
      wr_entry.width = req_word.entry_width;
      ram_addr       = load_write ? idx_wide[AW-1:0] : srch_addr;
   end

   gal_table_ram #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (load_write),
      .addr    (ram_addr),
      .wr_data (wr_entry),
      .rd_data (rd_entry)
   );

   // Classify the character and issue lookups
   always_comb begin
      is_space   = (char_ff == space_char_ff);
      is_end     = (char_ff == CHAR_NUL) || (char_ff == CHAR_NEWLINE);
      is_lower   = char_ff inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
      upper_char = char_ff - (CHAR_LOWER_A - CHAR_UPPER_A);
      srch_cmd.count = glyph_count_ff;
      srch_cmd.code  = {16'b0, char_ff};
      srch_cmd.start = 1'b0;
      if (state_ff == T_CHAR) begin
         srch_cmd.start = !line_done_ff && !is_end && (mono_advance_ff == 10'd0)
                          && !is_space;
      end else if (state_ff == T_SRCH1) begin
         srch_cmd.code  = {16'b0, upper_char};
         srch_cmd.start = srch_res.done && !srch_res.found && is_lower;
      end
      glyph_adv = $signed({4'b0, srch_res.width}) + {{4{glyph_spacing_ff[7]}}, glyph_spacing_ff};
      space_adv = $signed({2'b0, space_width_ff});
   end

   gal_search #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_search (
      .clock   (clock),
      .reset   (reset),
      .cmd     (srch_cmd),
      .rd_data (rd_entry),
      .rd_addr (srch_addr),
      .res     (srch_res)
   );

   // Accumulate with saturation and decide the break
   always_comb begin
      sum_wide = {sum_ff[19], sum_ff} + {{9{adv_ff[11]}}, adv_ff};
      if (sum_wide[20] != sum_wide[19]) begin
         sum_new = sum_wide[20] ? 20'sh80000 : 20'sh7FFFF;
      end else begin
         sum_new = sum_wide[19:0];
      end
      lsp_new    = is_space ? $signed({1'b0, pos_ff}) : lsp_ff;
      over_width = (sum_new > $signed({4'b0, max_width_ff})) && (pos_ff != 16'd0);
      pos_new    = (pos_ff < POS_MAX) ? pos_ff + 16'd1 : pos_ff;
      finish_wait = emit_ff && rsp_valid_ff && rsp_stall;
      rsp_load    = (state_ff == T_FINISH) && emit_ff && !finish_wait;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= T_IDLE;
         rsp_valid_ff     <= 1'b0;
         sum_ff           <= '0;
         pos_ff           <= '0;
         lsp_ff           <= '1;
         line_done_ff     <= 1'b0;
         space_char_ff    <= 16'd32;
         space_width_ff   <= '0;
         glyph_spacing_ff <= '0;
         mono_advance_ff  <= '0;
         max_width_ff     <= '0;
         glyph_count_ff   <= '0;
      end else begin
         // Configuration writes
         if (csr_write) begin
            case (csr_index)
               CSR_SPACE_CHAR:    space_char_ff    <= csr_data;
               CSR_SPACE_WIDTH:   space_width_ff   <= csr_data[9:0];
               CSR_GLYPH_SPACING: glyph_spacing_ff <= $signed(csr_data[7:0]);
               CSR_MONO_ADVANCE:  mono_advance_ff  <= csr_data[9:0];
               CSR_MAX_WIDTH:     max_width_ff     <= csr_data;
               CSR_GLYPH_COUNT:   glyph_count_ff   <= csr_data[12:0];
               default: ;
            endcase
         end

         // Drop the result word once taken, unless a new one replaces it
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            T_IDLE: begin
               if (req_accept && (req_word.operation == OP_TEXT)) begin
                  char_ff  <= req_word.text_char;
                  last_ff  <= req_word.text_last;
                  state_ff <= T_CHAR;
               end
            end
            T_CHAR: begin
               emit_ff <= 1'b0;
               if (line_done_ff) begin
                  state_ff <= T_FINISH;
               end else if (is_end) begin
                  emit_ff               <= 1'b1;
                  line_done_ff          <= 1'b1;
                  result_ff.break_count <= pos_ff;
                  result_ff.break_cause <= CAUSE_NEWLINE;
                  state_ff              <= T_FINISH;
               end else if (mono_advance_ff != 10'd0) begin
                  adv_ff   <= $signed({2'b0, mono_advance_ff});
                  state_ff <= T_ADD;
               end else if (is_space) begin
                  adv_ff   <= space_adv;
                  state_ff <= T_ADD;
               end else begin
                  state_ff <= T_SRCH1;
               end
            end
            T_SRCH1: begin
               if (srch_res.done) begin
                  if (srch_res.found) begin
                     adv_ff   <= glyph_adv;
                     state_ff <= T_ADD;
                  end else if (is_lower) begin
                     state_ff <= T_SRCH2;
                  end else begin
                     adv_ff   <= space_adv;
                     state_ff <= T_ADD;
                  end
               end
            end
            T_SRCH2: begin
               if (srch_res.done) begin
                  adv_ff   <= srch_res.found ? glyph_adv : space_adv;
                  state_ff <= T_ADD;
               end
            end
            T_ADD: begin
               sum_ff <= sum_new;
               lsp_ff <= lsp_new;
               if (over_width) begin
                  emit_ff      <= 1'b1;
                  line_done_ff <= 1'b1;
                  if (!lsp_new[16] && (lsp_new != 17'sd0)) begin
                     result_ff.break_count <= lsp_new[15:0];
                     result_ff.break_cause <= CAUSE_SPACE;
                  end else begin
                     result_ff.break_count <= pos_ff;
                     result_ff.break_cause <= CAUSE_MID;
                  end
               end else begin
                  pos_ff <= pos_new;
                  if (last_ff) begin
                     emit_ff               <= 1'b1;
                     line_done_ff          <= 1'b1;
                     result_ff.break_count <= pos_new;
                     result_ff.break_cause <= CAUSE_END;
                  end
               end
               state_ff <= T_FINISH;
            end
            T_FINISH: begin
               // Hold until the output register is free
               if (!finish_wait) begin
                  if (emit_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_word_ff  <= result_ff;
                  end
                  if (last_ff) begin
                     sum_ff       <= '0;
                     pos_ff       <= '0;
                     lsp_ff       <= '1;
                     line_done_ff <= 1'b0;
                  end
                  state_ff <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == T_FINISH) && $past(emit_ff))
      else $error("result word raised outside of line finish");

   a_search_done_expected: assert property (@(posedge clock) disable iff (reset)
      srch_res.done |-> (state_ff == T_SRCH1) || (state_ff == T_SRCH2))
      else $error("lookup finished while no lookup was pending");

   a_last_clears_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_FINISH) && last_ff && !finish_wait |=>
         (pos_ff == 16'd0) && !line_done_ff && (sum_ff == 20'sd0))
      else $error("line state not cleared after the final character");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gal_pkg::*;

   localparam int TABLE_SIZE   = 4096;
   localparam int TABLE_FILL   = 160;
   localparam int DRAIN_CYCLES = 48;
   localparam int RANDOM_CHARS = 750;
   localparam int SUM_HIGH     = 524287;
   localparam int SUM_LOW      = -524288;
   localparam int HOLD_CYCLES  = 300;
   localparam logic [15:0] CHAR_SPACE = 16'd32;

   typedef enum logic [1:0] {ROW_LOAD, ROW_TEXT, ROW_REG} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      req_word_type                    word;
      logic [CSR_INDEX_BITS-1:0]       reg_index;
      logic [CSR_DATA_BITS-1:0]        reg_value;
      bit                              typed;
      bit                              typed_has;
      rsp_word_type                    typed_brk;
   } stim_row_type;

   logic                      clock;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_word_type              req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data  = '0;

   // Mirror of the glyph table and the line state
   logic [31:0]       glyph_codes  [TABLE_SIZE];
   logic [7:0]        glyph_widths [TABLE_SIZE];
   int                line_sum    = 0;
   int                line_pos    = 0;
   int                last_space  = -1;
   bit                line_done   = 1'b0;

   // Mirror of the layout registers, at their reset values
   logic [15:0]       r_space_char  = CHAR_SPACE;
   logic [9:0]        r_space_width = '0;
   logic signed [7:0] r_spacing     = '0;
   logic [9:0]        r_mono        = '0;
   logic [15:0]       r_max_width   = '0;
   logic [12:0]       r_glyph_count = '0;

   rsp_word_type      pending_breaks [$];
   int                wrap_errors    = 0;
   int                random_chars   = 0;
   bit                req_idling     = 1'b1;
   bit                rsp_idling     = 1'b1;
   bit                rsp_hold_request = 1'b0;

   glyph_advance_line_breaker_top #(.TABLE_ENTRIES(TABLE_SIZE)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Binary search over the valid part of the table, -1 on a miss
   function automatic int find_glyph(input logic [31:0] code);
      int lo;
      int hi;
      int mid;
      int n;
      n = (r_glyph_count > TABLE_SIZE) ? TABLE_SIZE : int'(r_glyph_count);
      lo = 0;
      hi = n - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (glyph_codes[mid] == code) return mid;
         if (glyph_codes[mid] < code) lo = mid + 1;
         else hi = mid - 1;
      end
      return -1;
   endfunction

   function automatic int glyph_advance(input logic [15:0] ch);
      int slot;
      if (r_mono != 0) return int'(r_mono);
      if (ch == r_space_char) return int'(r_space_width);
      slot = find_glyph({16'd0, ch});
      // retry a lowercase miss as uppercase
      if (slot < 0 && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
         slot = find_glyph({16'd0, 16'(ch - CHAR_LOWER_A + CHAR_UPPER_A)});
      if (slot < 0) return int'(r_space_width);
      return int'(glyph_widths[slot]) + int'(r_spacing);
   endfunction

   // Advance the mirrored line state by one word, return the break it decides
   task automatic wrap_step(input req_word_type w, output bit has, output rsp_word_type brk);
      int s;
      has = 1'b0;
      brk = '0;
      if (w.operation == OP_LOAD) begin
         glyph_codes[w.entry_index]  = w.entry_code;
         glyph_widths[w.entry_index] = w.entry_width;
         return;
      end
      if (!line_done) begin
         if (w.text_char == CHAR_NUL || w.text_char == CHAR_NEWLINE) begin
            brk.break_count = 16'(line_pos);
            brk.break_cause = CAUSE_NEWLINE;
            has = 1'b1;
         end else begin
            if (w.text_char == r_space_char) last_space = line_pos;
            s = line_sum + glyph_advance(w.text_char);
            if (s > SUM_HIGH) s = SUM_HIGH;
            if (s < SUM_LOW) s = SUM_LOW;
            line_sum = s;
            if (line_sum > int'(r_max_width) && line_pos > 0) begin
               // a space at the start of the line is no break point
               if (last_space > 0) begin
                  brk.break_count = 16'(last_space);
                  brk.break_cause = CAUSE_SPACE;
               end else begin
                  brk.break_count = 16'(line_pos);
                  brk.break_cause = CAUSE_MID;
               end
               has = 1'b1;
            end else begin
               if (line_pos < int'(POS_MAX)) line_pos++;
               if (w.text_last) begin
                  brk.break_count = 16'(line_pos);
                  brk.break_cause = CAUSE_END;
                  has = 1'b1;
               end
            end
         end
         if (has) line_done = 1'b1;
      end
      if (w.text_last) begin
         line_sum   = 0;
         line_pos   = 0;
         last_space = -1;
         line_done  = 1'b0;
      end
   endtask

   function automatic req_word_type text_word(input logic [15:0] ch, input bit last);
      req_word_type w;
      w.operation   = OP_TEXT;
      w.entry_index = 12'($urandom);
      w.entry_code  = $urandom;
      w.entry_width = 8'($urandom);
      w.text_char   = ch;
      w.text_last   = last;
      return w;
   endfunction

   function automatic req_word_type load_word(input logic [11:0] idx, input logic [31:0] code,
                                              input logic [7:0] width);
      req_word_type w;
      w.operation   = OP_LOAD;
      w.entry_index = idx;
      w.entry_code  = code;
      w.entry_width = width;
      w.text_char   = 16'($urandom);
      w.text_last   = 1'($urandom);
      return w;
   endfunction

   function automatic stim_row_type text_row(input logic [15:0] ch, input bit last);
      stim_row_type r;
      r.kind      = ROW_TEXT;
      r.word      = text_word(ch, last);
      r.reg_index = '0;
      r.reg_value = '0;
      r.typed     = 1'b0;
      r.typed_has = 1'b0;
      r.typed_brk = '0;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [15:0] ch, input bit last,
                                              input bit has, input logic [15:0] count,
                                              input logic [1:0] cause);
      stim_row_type r;
      r = text_row(ch, last);
      r.typed     = 1'b1;
      r.typed_has = has;
      r.typed_brk.break_count = count;
      r.typed_brk.break_cause = cause;
      return r;
   endfunction

   function automatic stim_row_type load_row(input logic [11:0] idx, input logic [31:0] code,
                                             input logic [7:0] width);
      stim_row_type r;
      r = text_row(CHAR_NUL, 1'b0);
      r.kind = ROW_LOAD;
      r.word = load_word(idx, code, width);
      return r;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_INDEX_BITS-1:0] idx,
                                            input logic [CSR_DATA_BITS-1:0] value);
      stim_row_type r;
      r = text_row(CHAR_NUL, 1'b0);
      r.kind      = ROW_REG;
      r.reg_index = idx;
      r.reg_value = value;
      return r;
   endfunction

   // Offer one word, hold it until taken, then queue what it should produce
   task automatic send_word(input req_word_type w, input bit typed, input bit typed_has,
                            input rsp_word_type typed_brk);
      bit           has;
      rsp_word_type brk;
      while (req_idling && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      wrap_step(w, has, brk);
      if (typed) begin
         has = typed_has;
         brk = typed_brk;
      end
      if (has) pending_breaks.push_back(brk);
   endtask

   // Drop valid, wait for every break, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_breaks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_SPACE_CHAR:    r_space_char  = value;
         CSR_SPACE_WIDTH:   r_space_width = value[9:0];
         CSR_GLYPH_SPACING: r_spacing     = value[7:0];
         CSR_MONO_ADVANCE:  r_mono        = value[9:0];
         CSR_MAX_WIDTH:     r_max_width   = value;
         CSR_GLYPH_COUNT:   r_glyph_count = value[12:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Fill slots 0..entries-1 with ascending codes, ASCII first, top code last
   task automatic load_table(input int entries, input bit with_lower);
      longint unsigned code;
      code = 0;
      for (int i = 0; i < entries; i++) begin
         if (i == entries - 1) code = 32'hFFFF_FFFF;
         send_word(load_word(12'(i), code[31:0], 8'($urandom_range(0, 255))), 1'b0, 1'b0, '0);
         if (code < 127) begin
            code++;
            while (!with_lower && code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) code++;
         end else begin
            code += $urandom_range(1, 1_000_000);
         end
      end
   endtask

   function automatic logic [15:0] pick_char();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return CHAR_UPPER_A + 16'($urandom_range(0, 25));
      if (roll < 55) return CHAR_LOWER_A + 16'($urandom_range(0, 25));
      if (roll < 72) return r_space_char;
      if (roll < 76) return $urandom_range(1) ? CHAR_NEWLINE : CHAR_NUL;
      if (roll < 84) return 16'($urandom);
      return 16'($urandom_range(0, 127));
   endfunction

   task automatic send_string(input int len, input bit broken);
      for (int i = 0; i < len; i++) begin
         send_word(text_word(pick_char(), (i == len - 1) && !broken), 1'b0, 1'b0, '0);
         random_chars++;
      end
   endtask

   // Choose the layout for one phase, the first phases pinned to extremes
   task automatic set_layout(input int phase, input int table_len);
      logic [15:0] sc;
      logic [15:0] sw;
      logic [15:0] sp;
      logic [15:0] mono;
      logic [15:0] maxw;
      logic [15:0] cnt;
      int          roll;
      roll = $urandom_range(99);
      sc = (roll < 70) ? CHAR_SPACE :
           (roll < 85) ? CHAR_LOWER_A + 16'($urandom_range(0, 25)) : 16'($urandom);
      sw = $urandom_range(1) ? 16'($urandom_range(0, 16)) : 16'($urandom_range(0, 1023));
      sp = 16'($urandom);
      mono = ($urandom_range(99) < 75) ? 16'd0 : 16'($urandom_range(1, 1023));
      case ($urandom_range(2))
         0: maxw = 16'($urandom_range(0, 100));
         1: maxw = 16'($urandom_range(0, 3000));
         default: maxw = 16'($urandom);
      endcase
      cnt = $urandom_range(1) ? 16'(table_len) : 16'($urandom_range(0, TABLE_FILL));
      case (phase)
         0: begin
            sc = CHAR_SPACE; sw = 16'd0; sp = 16'h0080; mono = 16'd0; maxw = 16'd0;
            cnt = 16'(TABLE_FILL);
         end
         1: begin
            sc = 16'hFFFF; sw = 16'd1023; sp = 16'h007F; mono = 16'd1023; maxw = 16'hFFFF;
            cnt = 16'd0;
         end
         2: begin
            mono = 16'd0; maxw = 16'd500; cnt = 16'(TABLE_FILL);
         end
         default: ;
      endcase
      write_reg(CSR_SPACE_CHAR, sc);
      write_reg(CSR_SPACE_WIDTH, sw);
      write_reg(CSR_GLYPH_SPACING, sp);
      write_reg(CSR_MONO_ADVANCE, mono);
      write_reg(CSR_MAX_WIDTH, maxw);
      write_reg(CSR_GLYPH_COUNT, cnt);
   endtask

   // Receiver: check each taken word, then pick the next stall
   initial begin
      rsp_word_type want;
      int           hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_breaks.size() == 0) begin
               $display("%0t: unexpected break: count %0d cause %0d", $time,
                        rsp_word.break_count, rsp_word.break_cause);
               wrap_errors++;
            end else begin
               want = pending_breaks.pop_front();
               if (rsp_word.break_count !== want.break_count) begin
                  $display("%0t: break_count expected %0d got %0d", $time,
                           want.break_count, rsp_word.break_count);
                  wrap_errors++;
               end
               if (rsp_word.break_cause !== want.break_cause) begin
                  $display("%0t: break_cause expected %0d got %0d", $time,
                           want.break_cause, rsp_word.break_cause);
                  wrap_errors++;
               end
            end
         end
         if (rsp_hold_request) begin
            hold_left = HOLD_CYCLES;
            rsp_hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rsp_idling && ($urandom_range(99) < 19);
         end
      end
   end

   // Sender: directed rows, glyph table, random phases, negative sum run
   initial begin
      stim_row_type directed_rows [$];
      int           table_len;

      // empty table, reset layout
      directed_rows.push_back(text_row("H", 1'b0));
      directed_rows.push_back(typed_row("i", 1'b1, 1'b1, 16'd2, CAUSE_END));
      directed_rows.push_back(typed_row(CHAR_NEWLINE, 1'b0, 1'b1, 16'd0, CAUSE_NEWLINE));
      directed_rows.push_back(typed_row("x", 1'b1, 1'b0, 16'd0, CAUSE_END));
      directed_rows.push_back(text_row("a", 1'b0));
      directed_rows.push_back(typed_row(CHAR_NUL, 1'b1, 1'b1, 16'd1, CAUSE_NEWLINE));
      // fixed advance of 3, line of 8
      directed_rows.push_back(reg_row(CSR_MONO_ADVANCE, 16'd3));
      directed_rows.push_back(reg_row(CSR_MAX_WIDTH, 16'd8));
      directed_rows.push_back(text_row("a", 1'b0));
      directed_rows.push_back(text_row(" ", 1'b0));
      directed_rows.push_back(typed_row("b", 1'b0, 1'b1, 16'd1, CAUSE_SPACE));
      directed_rows.push_back(typed_row("c", 1'b1, 1'b0, 16'd0, CAUSE_END));
      // leading space is no break point
      directed_rows.push_back(text_row(" ", 1'b0));
      directed_rows.push_back(text_row("a", 1'b0));
      directed_rows.push_back(typed_row("b", 1'b1, 1'b1, 16'd2, CAUSE_MID));
      // three-entry table, extreme code and width
      directed_rows.push_back(load_row(12'd0, 32'd65, 8'hFF));
      directed_rows.push_back(load_row(12'd1, 32'd98, 8'h00));
      directed_rows.push_back(load_row(12'd2, 32'hFFFF_FFFF, 8'd7));
      directed_rows.push_back(load_row(12'hFFF, 32'h1234_5678, 8'h80));
      directed_rows.push_back(reg_row(CSR_MONO_ADVANCE, 16'd0));
      directed_rows.push_back(reg_row(CSR_GLYPH_SPACING, 16'h0080));
      directed_rows.push_back(reg_row(CSR_SPACE_WIDTH, 16'd1023));
      directed_rows.push_back(reg_row(CSR_MAX_WIDTH, 16'd200));
      directed_rows.push_back(reg_row(CSR_SPACE_CHAR, 16'hFFFF));
      directed_rows.push_back(reg_row(CSR_GLYPH_COUNT, 16'd3));
      // lowercase fallback, negative advance, unknown glyph
      directed_rows.push_back(text_row("a", 1'b0));
      directed_rows.push_back(text_row("b", 1'b0));
      directed_rows.push_back(text_row("z", 1'b0));
      directed_rows.push_back(text_row(16'hFFFF, 1'b1));
      directed_rows.push_back(text_row(16'hFFFF, 1'b0));
      directed_rows.push_back(text_row("A", 1'b0));
      directed_rows.push_back(text_row("A", 1'b1));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_REG) begin
            settle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_word(directed_rows[i].word, directed_rows[i].typed,
                      directed_rows[i].typed_has, directed_rows[i].typed_brk);
         end
      end

      // slots below TABLE_FILL written from here on; glyph_count stays within them
      load_table(TABLE_FILL, 1'b1);

      for (int phase = 0; random_chars < RANDOM_CHARS; phase++) begin
         settle();
         table_len = TABLE_FILL;
         if (phase > 2 && $urandom_range(99) < 30) begin
            table_len = $urandom_range(1, 120);
            load_table(table_len, 1'($urandom_range(1)));
            settle();
         end
         set_layout(phase, table_len);
         if (phase == 2) rsp_hold_request = 1'b1;
         for (int s = 0; s < 10; s++) begin
            if ($urandom_range(99) < 5)
               send_word(load_word(12'($urandom), $urandom, 8'($urandom)), 1'b0, 1'b0, '0);
            send_string($urandom_range(1, 24), $urandom_range(99) < 5);
         end
      end

      // drive the sum negative, then climb back with spaces
      settle();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      send_word(load_word(12'd0, {16'd0, CHAR_UPPER_A}, 8'd0), 1'b0, 1'b0, '0);
      settle();
      write_reg(CSR_MONO_ADVANCE, 16'd0);
      write_reg(CSR_SPACE_CHAR, CHAR_SPACE);
      write_reg(CSR_GLYPH_SPACING, 16'h0080);
      write_reg(CSR_SPACE_WIDTH, 16'd1023);
      write_reg(CSR_MAX_WIDTH, 16'd0);
      write_reg(CSR_GLYPH_COUNT, 16'd1);
      for (int i = 0; i < 120; i++)
         send_word(text_word(CHAR_UPPER_A, 1'b0), 1'b0, 1'b0, '0);
      for (int i = 0; i < 30; i++)
         send_word(text_word(CHAR_SPACE, i == 29), 1'b0, 1'b0, '0);

      settle();
      if (wrap_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
